/* rtl/gbe_pkg.sv */
// Shared types, constants and round functions for the 28147-89 ECB encrypt pipeline.
package gbe_pkg;

    localparam int NumRounds  = 32;
    localparam int NumKeyRegs = 4;
    localparam int ApbAddrW   = 5;
    localparam int ApbDataW   = 64;
    localparam int WordW      = 32;
    localparam int RotAmt     = 11;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
    } blk_t;

    typedef logic [7:0][WordW-1:0] key_words_t;

    localparam logic [7:0] SBOX [64] = '{
        8'hc4, 8'hed, 8'h83, 8'hc9, 8'h92, 8'h98, 8'hfe, 8'h6b,
        8'hff, 8'hbe, 8'h65, 8'h5c, 8'he5, 8'h2c, 8'hb9, 8'h20,
        8'h89, 8'h57, 8'h16, 8'hb3, 8'h11, 8'hf3, 8'h98, 8'h06,
        8'h30, 8'h79, 8'hc0, 8'h97, 8'ha8, 8'h1a, 8'h5d, 8'hd5,
        8'h2e, 8'h01, 8'hda, 8'h34, 8'h73, 8'hd5, 8'h3b, 8'he8,
        8'h4b, 8'hc2, 8'h77, 8'h7e, 8'hdc, 8'h64, 8'hac, 8'haf,
        8'h6d, 8'ha6, 8'h02, 8'hf1, 8'h07, 8'h4f, 8'he1, 8'h4a,
        8'hba, 8'h30, 8'h2f, 8'h12, 8'h56, 8'h8b, 8'h44, 8'h8d
    };

    // nibble k of row word j; row word j is bytes 4j..4j+3, little-endian
    function automatic logic [3:0] sbox_nib(input logic [2:0] k, input logic [3:0] j);
        logic [7:0] bval;
        bval = SBOX[{j, k[2:1]}];
        return k[0] ? bval[7:4] : bval[3:0];
    endfunction

    function automatic word_t substitute(input word_t x);
        word_t r;
        for (int k = 0; k < 8; k++)
        begin
            r[4*k +: 4] = sbox_nib(3'(k), x[4*k +: 4]);
        end
        return r;
    endfunction

    // rounds 0..23 cycle through key words, rounds 24..31 run them backward
    function automatic logic [2:0] round_key_idx(input int i);
        return (i < 24) ? 3'(i) : 3'(31 - i);
    endfunction

endpackage

/* rtl/gbe_regs.sv */
// APB key register file: four 64-bit registers holding the eight key words.
module gbe_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbe_pkg::ApbAddrW-1:0] paddr,
    input  logic [gbe_pkg::ApbDataW-1:0] pwdata,
    output logic [gbe_pkg::ApbDataW-1:0] prdata,
    output logic                         pready,
    output gbe_pkg::key_words_t          key_words
);
    import gbe_pkg::*;

    logic [NumKeyRegs-1:0][ApbDataW-1:0] key_reg;
    logic [NumKeyRegs-1:0][ApbDataW-1:0] key_next;
    logic [1:0]                          reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            key_next[reg_idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign prdata = key_reg[reg_idx];

    always_comb
    begin
        for (int i = 0; i < NumKeyRegs; i++)
        begin
            key_words[2*i]     = key_reg[i][WordW-1:0];
            key_words[2*i + 1] = key_reg[i][ApbDataW-1:WordW];
        end
    end

endmodule

/* rtl/gbe_round.sv */
// One registered Feistel round: add key, substitute, rotate, xor, swap.
module gbe_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  gbe_pkg::blk_t        in_blk,
    input  gbe_pkg::word_t       round_key,
    output logic                 out_valid,
    output gbe_pkg::blk_t        out_blk
);
    import gbe_pkg::*;

    logic  valid_reg;
    blk_t  blk_reg;
    blk_t  blk_next;
    word_t sum;
    word_t sub;
    word_t rot;

    assign sum = in_blk.a + round_key;
    assign sub = substitute(sum);
    assign rot = {sub[WordW-RotAmt-1:0], sub[WordW-1:WordW-RotAmt]};

    assign blk_next.a = in_blk.b ^ rot;
    assign blk_next.b = in_blk.a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

/* rtl/gost_block_encrypt_ecb_unit.sv */
// Top level: 28147-89 ECB block encryption, 32-stage round pipeline.
// Usage:
//   Load the eight key words through the APB port (four 64-bit registers at
//   byte addresses 0, 8, 16, 24) while no word is in flight.
//   Present plain_low/plain_high with start high; the word is taken at the
//   clock edge where start is high and busy is low. busy is always low, so
//   a new word may enter every cycle.
//   Each word runs through 32 registered stages, one round each. Its result
//   shows on cipher_low/cipher_high with done high for exactly one cycle,
//   once the word has passed the last stage register. Throughput: one word
//   per clock.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset clears all stage valid bits and the key registers to zero.
module gost_block_encrypt_ecb_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbe_pkg::ApbAddrW-1:0] paddr,
    input  logic [gbe_pkg::ApbDataW-1:0] pwdata,
    output logic [gbe_pkg::ApbDataW-1:0] prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  gbe_pkg::word_t               plain_low,
    input  gbe_pkg::word_t               plain_high,
    output logic                         done,
    output gbe_pkg::word_t               cipher_low,
    output gbe_pkg::word_t               cipher_high
);
    import gbe_pkg::*;

    key_words_t key_words;
    logic       vld [NumRounds+1];
    blk_t       blk [NumRounds+1];

    gbe_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .key_words (key_words)
    );

    assign busy     = 1'b0;
    assign vld[0]   = start;
    assign blk[0].a = plain_low;
    assign blk[0].b = plain_high;

    for (genvar i = 0; i < NumRounds; i++)
    begin : g_round
        gbe_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_blk    (blk[i]),
            .round_key (key_words[round_key_idx(i)]),
            .out_valid (vld[i+1]),
            .out_blk   (blk[i+1])
        );
    end

    assign done        = vld[NumRounds];
    assign cipher_low  = blk[NumRounds].b;
    assign cipher_high = blk[NumRounds].a;

endmodule

/* tb/gost_block_encrypt_ecb_unit_tb.sv */
// Self-checking testbench for the 28147-89 ECB block encrypt pipeline.
package gbe_tb_pkg;
    import gbe_pkg::*;

    typedef enum int {
        KEY_WORDS_0_1,
        KEY_WORDS_2_3,
        KEY_WORDS_4_5,
        KEY_WORDS_6_7
    } key_reg_e;

    typedef struct packed {
        word_t lo;
        word_t hi;
    } cipher_t;

    localparam bit [7:0] SubstTbl [64] = '{
        8'hc4, 8'hed, 8'h83, 8'hc9, 8'h92, 8'h98, 8'hfe, 8'h6b,
        8'hff, 8'hbe, 8'h65, 8'h5c, 8'he5, 8'h2c, 8'hb9, 8'h20,
        8'h89, 8'h57, 8'h16, 8'hb3, 8'h11, 8'hf3, 8'h98, 8'h06,
        8'h30, 8'h79, 8'hc0, 8'h97, 8'ha8, 8'h1a, 8'h5d, 8'hd5,
        8'h2e, 8'h01, 8'hda, 8'h34, 8'h73, 8'hd5, 8'h3b, 8'he8,
        8'h4b, 8'hc2, 8'h77, 8'h7e, 8'hdc, 8'h64, 8'hac, 8'haf,
        8'h6d, 8'ha6, 8'h02, 8'hf1, 8'h07, 8'h4f, 8'he1, 8'h4a,
        8'hba, 8'h30, 8'h2f, 8'h12, 8'h56, 8'h8b, 8'h44, 8'h8d
    };

    function automatic word_t subst_word(input word_t x);
        word_t r;
        int j;
        bit [7:0] row_byte;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            j = int'(x[4*k +: 4]);
            row_byte = SubstTbl[4*j + k/2];
            r[4*k +: 4] = (k % 2 == 1) ? row_byte[7:4] : row_byte[3:0];
        end
        return r;
    endfunction

    function automatic cipher_t gost_encrypt(input word_t lo, input word_t hi,
                                             input word_t key [8]);
        word_t a;
        word_t b;
        word_t s;
        word_t t;
        int ki;
        cipher_t c;
        a = lo;
        b = hi;
        for (int i = 0; i < 32; i++)
        begin
            ki = (i < 24) ? (i % 8) : (31 - i);
            s = subst_word(a + key[ki]);
            t = b ^ {s[20:0], s[31:21]};
            b = a;
            a = t;
        end
        c.lo = b;
        c.hi = a;
        return c;
    endfunction

    class ecb_cipher_board;
        word_t   key_w [8] = '{default: '0};
        cipher_t pending_cipher [$];
        int      n_blocks;
        int      n_checked;
        int      n_errors;

        function void load_key(key_reg_e r, logic [63:0] v);
            key_w[2*int'(r)]     = v[31:0];
            key_w[2*int'(r) + 1] = v[63:32];
        endfunction

        function logic [63:0] key_reg(key_reg_e r);
            return {key_w[2*int'(r) + 1], key_w[2*int'(r)]};
        endfunction

        function void note_plain(word_t lo, word_t hi);
            pending_cipher.push_back(gost_encrypt(lo, hi, key_w));
            n_blocks++;
        endfunction

        function void check_cipher(word_t lo, word_t hi);
            cipher_t want;
            if (pending_cipher.size() == 0)
            begin
                $display("%0t: unexpected cipher word, expected none, got lo=%h hi=%h",
                         $time, lo, hi);
                n_errors++;
                return;
            end
            want = pending_cipher.pop_front();
            n_checked++;
            if (lo !== want.lo)
            begin
                $display("%0t: cipher_low mismatch, expected %h, got %h",
                         $time, want.lo, lo);
                n_errors++;
            end
            if (hi !== want.hi)
            begin
                $display("%0t: cipher_high mismatch, expected %h, got %h",
                         $time, want.hi, hi);
                n_errors++;
            end
        endfunction
    endclass
endpackage

module gost_block_encrypt_ecb_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbe_pkg::*;
    import gbe_tb_pkg::*;

    localparam int CycleLimit       = 200000;
    localparam int PipeDepth        = 32;
    localparam int TailCycles       = 2 * PipeDepth;
    localparam int NumSettings      = 8;
    localparam int BlocksPerSetting = 104;
    localparam int NumDirected      = 16;

    localparam word_t DirLo [NumDirected] = '{
        32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff,
        32'h00000001, 32'h00000000, 32'h80000000, 32'h00000000,
        32'h55555555, 32'haaaaaaaa, 32'h76543210, 32'h89abcdef,
        32'h0f0f0f0f, 32'hf0f0f0f0, 32'h7fffffff, 32'hfffffffe
    };
    localparam word_t DirHi [NumDirected] = '{
        32'h00000000, 32'hffffffff, 32'hffffffff, 32'h00000000,
        32'h00000000, 32'h00000001, 32'h00000000, 32'h80000000,
        32'haaaaaaaa, 32'h55555555, 32'hfedcba98, 32'h01234567,
        32'hf0f0f0f0, 32'h0f0f0f0f, 32'hfffffffe, 32'h7fffffff
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;
    logic                start;
    logic                busy;
    word_t               plain_low;
    word_t               plain_high;
    logic                done;
    word_t               cipher_low;
    word_t               cipher_high;

    ecb_cipher_board board;
    int              cycle_cnt;
    int              quiet_left;
    bit              idle_ok;

    gost_block_encrypt_ecb_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .plain_low  (plain_low),
        .plain_high (plain_high),
        .done       (done),
        .cipher_low (cipher_low),
        .cipher_high(cipher_high)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                board.note_plain(plain_low, plain_high);
            end
            if (done)
            begin
                board.check_cipher(cipher_low, cipher_high);
            end
        end
    end

    task automatic write_key(key_reg_e r, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ApbAddrW'(int'(r) * 8);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.load_key(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_key(key_reg_e r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ApbAddrW'(int'(r) * 8);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== board.key_reg(r))
        begin
            $display("%0t: %s readback mismatch, expected %h, got %h",
                     $time, r.name(), board.key_reg(r), prdata);
            board.n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_keys();
        read_key(KEY_WORDS_0_1);
        read_key(KEY_WORDS_2_3);
        read_key(KEY_WORDS_4_5);
        read_key(KEY_WORDS_6_7);
    endtask

    task automatic send_block(word_t lo, word_t hi);
        start      <= 1'b1;
        plain_low  <= lo;
        plain_high <= hi;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic idle_burst(int n);
        start      <= 1'b0;
        plain_low  <= $urandom;
        plain_high <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    // sender holds off until the pipeline has delivered every word in flight
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_cipher.size() != 0) @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (!idle_ok)
        begin
            return;
        end
        if (quiet_left > 0)
        begin
            quiet_left--;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            idle_burst($urandom_range(1, 14));
        end
    endtask

    task automatic next_plain(output word_t lo, output word_t hi);
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 9))
            0: lo = $urandom_range(0, 1) ? '1 : '0;
            1: hi = $urandom_range(0, 1) ? '1 : '0;
            2:
            begin
                lo = word_t'(1) << $urandom_range(0, 31);
                hi = ~(word_t'(1) << $urandom_range(0, 31));
            end
            default: ;
        endcase
    endtask

    initial
    begin
        logic [63:0] kv [4];
        word_t       lo;
        word_t       hi;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        plain_low  = '0;
        plain_high = '0;
        cycle_cnt  = 0;
        quiet_left = 0;
        idle_ok    = 1'b1;
        board      = new;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keys come out of reset as zero
        check_keys();
        for (int i = 0; i < NumDirected; i++)
        begin
            maybe_idle();
            send_block(DirLo[i], DirHi[i]);
        end
        drain();

        for (int s = 0; s < NumSettings; s++)
        begin
            idle_ok = (s != NumSettings - 1);
            for (int r = 0; r < 4; r++)
            begin
                case (s)
                    0:                kv[r] = '1;
                    1:                kv[r] = 64'haaaaaaaa_55555555;
                    NumSettings - 1:  kv[r] = '0;
                    default:          kv[r] = {$urandom, $urandom};
                endcase
            end
            if (s == 2)
            begin
                kv[$urandom_range(0, 3)] = 64'hffffffff_00000000;
            end
            write_key(KEY_WORDS_0_1, kv[0]);
            write_key(KEY_WORDS_2_3, kv[1]);
            write_key(KEY_WORDS_4_5, kv[2]);
            write_key(KEY_WORDS_6_7, kv[3]);
            check_keys();

            for (int n = 0; n < BlocksPerSetting; n++)
            begin
                if (s == 3 && n == BlocksPerSetting / 2)
                begin
                    drain();
                end
                maybe_idle();
                next_plain(lo, hi);
                send_block(lo, hi);
            end
            drain();
        end

        repeat (TailCycles) @(posedge clk);

        $display("encrypted %0d blocks under %0d key sets, %0d cipher words checked",
                 board.n_blocks, NumSettings + 1, board.n_checked);
        $display("%0d errors, %0d words still outstanding",
                 board.n_errors, board.pending_cipher.size());
        if (board.n_errors == 0 && board.pending_cipher.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gbe_pkg.sv
rtl/gbe_regs.sv
rtl/gbe_round.sv
rtl/gost_block_encrypt_ecb_unit.sv
tb/gost_block_encrypt_ecb_unit_tb.sv
